### sv/impq_pkg.sv
// Package for the indexed max priority queue unit.
// Holds command codes, field widths, default sizes and the level saturation helper.
// No dependencies.
package impq_pkg;

  localparam int unsigned DEF_NUM_ENTRIES = 256;
  localparam int unsigned DEF_STAMP_BITS  = 20;

  localparam int unsigned CMD_W   = 2;
  localparam int unsigned ID_W    = 8;
  localparam int unsigned LEVEL_W = 7;

  localparam int unsigned LEVEL_MAX = 100;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT   = 2'd0,
    CMD_INCREASE = 2'd1,
    CMD_REMOVE   = 2'd2,
    CMD_QUERY    = 2'd3
  } cmd_t;

  // Clamps a level (or a level plus an increment) to the largest legal level.
  function automatic logic [LEVEL_W-1:0] sat_level(input logic [LEVEL_W:0] v);
    logic [LEVEL_W-1:0] res;
    if (v > (LEVEL_W+1)'(LEVEL_MAX)) begin
      res = LEVEL_W'(LEVEL_MAX);
    end else begin
      res = v[LEVEL_W-1:0];
    end
    return res;
  endfunction

endpackage

### sv/indexed_max_priority_queue_unit.sv
// Top level of the indexed max priority queue unit: sequencer, slot memory and output register.
// Depends on impq_pkg and instantiates impq_cmp.
//
//   channel | direction | ports                                          | handshake
//   in      | input     | in_cmd, in_entry_id, in_level_value            | in_valid / in_stall
//   out     | output    | out_is_empty, out_best_id                      | out_valid / out_stall
//
// Insert and remove write the slot directly from the idle state. An increase first reads the slot
// from memory and then, in S_INC, writes the updated level back.
// A query reads the slot memory through its single read port, one entry per cycle, and
// ranks each entry with one shared comparator.
// After reset the unit writes every slot as empty and holds in_stall high during that pass.
// A finished query waits in the output register while the unit takes new transactions;
// only a second query result finding that register still full stalls the sequencer.
module indexed_max_priority_queue_unit
  import impq_pkg::*;
#(
  parameter int unsigned NUM_ENTRIES = DEF_NUM_ENTRIES,
  parameter int unsigned STAMP_BITS  = DEF_STAMP_BITS
) (
  input  logic               clk,
  input  logic               rst_n,

  input  logic               in_valid,
  output logic               in_stall,
  input  logic [CMD_W-1:0]   in_cmd,
  input  logic [ID_W-1:0]    in_entry_id,
  input  logic [LEVEL_W-1:0] in_level_value,

  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_is_empty,
  output logic [ID_W-1:0]    out_best_id
);

  localparam int unsigned IDX_W  = $clog2(NUM_ENTRIES);
  localparam int unsigned WORD_W = 1 + LEVEL_W + STAMP_BITS;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_ENTRIES - 1);

  // One-hot sequencer states.
  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_INC   = 6'b000100,
    S_SCAN  = 6'b001000,
    S_DRAIN = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  state_t                state_r, state_nxt;
  logic [IDX_W-1:0]      cnt_r, cnt_nxt;
  logic [STAMP_BITS-1:0] cmd_count_r, cmd_count_nxt;

  // Operands held for the read-modify-write of an increase.
  logic [IDX_W-1:0]      op_idx_r, op_idx_nxt;
  logic [LEVEL_W-1:0]    op_delta_r, op_delta_nxt;

  // Running best entry of a query scan.
  logic                  best_found_r, best_found_nxt;
  logic [LEVEL_W-1:0]    best_level_r, best_level_nxt;
  logic [STAMP_BITS-1:0] best_stamp_r, best_stamp_nxt;
  logic [IDX_W-1:0]      best_idx_r, best_idx_nxt;

  // Read pipeline of the scan: rd_pend_r marks that rd_data_r holds entry rd_idx_r.
  logic                  rd_pend_r;
  logic [IDX_W-1:0]      rd_idx_r;

  // Slot memory: each word holds {valid, level, arrival stamp}.
  logic [WORD_W-1:0]     slot_mem_r [NUM_ENTRIES];
  logic [WORD_W-1:0]     rd_data_r;
  logic                  mem_we;
  logic [IDX_W-1:0]      mem_waddr;
  logic [WORD_W-1:0]     mem_wdata;
  logic [IDX_W-1:0]      mem_raddr;

  logic                  out_valid_r, out_valid_nxt;
  logic                  out_is_empty_r, out_is_empty_nxt;
  logic [ID_W-1:0]       out_best_id_r, out_best_id_nxt;

  logic                  in_accept;
  logic                  in_table;
  logic                  out_free;
  logic                  rd_valid;
  logic [LEVEL_W-1:0]    rd_level;
  logic [STAMP_BITS-1:0] rd_stamp;
  logic                  cand_better;
  logic [IDX_W-1:0]      in_idx;

  assign in_stall  = state_r != S_IDLE;
  assign in_accept = in_valid && !in_stall;
  assign in_idx    = IDX_W'(in_entry_id);
  // Ids at or above the table size are ignored by insert, increase and remove.
  assign in_table  = 32'(in_entry_id) < 32'(NUM_ENTRIES);
  assign out_free  = !out_valid_r || !out_stall;

  assign rd_valid = rd_data_r[WORD_W-1];
  assign rd_level = rd_data_r[WORD_W-2 -: LEVEL_W];
  assign rd_stamp = rd_data_r[STAMP_BITS-1:0];

  impq_cmp #(
    .STAMP_BITS(STAMP_BITS)
  ) u_cmp (
    .cand_valid(rd_valid),
    .cand_level(rd_level),
    .cand_stamp(rd_stamp),
    .best_found(best_found_r),
    .best_level(best_level_r),
    .best_stamp(best_stamp_r),
    .better    (cand_better)
  );

  // The read address follows the incoming id while idle, so an increase finds its
  // slot in rd_data_r in the cycle after it is accepted.
  assign mem_raddr = (state_r == S_IDLE) ? in_idx : cnt_r;

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = cnt_r;
    mem_wdata = '0;
    case (state_r)
      S_CLEAR: begin
        mem_we = 1'b1;
      end
      S_IDLE: begin
        mem_waddr = in_idx;
        if (in_accept && in_table) begin
          if (in_cmd == CMD_INSERT) begin
            mem_we    = 1'b1;
            mem_wdata = {1'b1, sat_level({1'b0, in_level_value}), cmd_count_r};
          end else if (in_cmd == CMD_REMOVE) begin
            mem_we = 1'b1;
          end
        end
      end
      S_INC: begin
        // An increase of an absent entry leaves the slot alone.
        mem_waddr = op_idx_r;
        mem_we    = rd_valid;
        mem_wdata = {1'b1, sat_level({1'b0, rd_level} + {1'b0, op_delta_r}), rd_stamp};
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      slot_mem_r[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= slot_mem_r[mem_raddr];
  end

  always_comb begin
    state_nxt        = state_r;
    cnt_nxt          = cnt_r;
    cmd_count_nxt    = cmd_count_r;
    op_idx_nxt       = op_idx_r;
    op_delta_nxt     = op_delta_r;
    best_found_nxt   = best_found_r;
    best_level_nxt   = best_level_r;
    best_stamp_nxt   = best_stamp_r;
    best_idx_nxt     = best_idx_r;
    out_valid_nxt    = out_valid_r && out_stall;
    out_is_empty_nxt = out_is_empty_r;
    out_best_id_nxt  = out_best_id_r;

    // Fold the entry that arrived from memory into the running best.
    if (rd_pend_r && cand_better) begin
      best_found_nxt = 1'b1;
      best_level_nxt = rd_level;
      best_stamp_nxt = rd_stamp;
      best_idx_nxt   = rd_idx_r;
    end

    case (state_r)
      S_CLEAR: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == LAST_IDX) begin
          cnt_nxt   = '0;
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_accept) begin
          // Every transaction, queries included, takes a stamp.
          cmd_count_nxt = cmd_count_r + 1'b1;
          op_idx_nxt    = in_idx;
          op_delta_nxt  = in_level_value;
          if (in_cmd == CMD_QUERY) begin
            cnt_nxt        = '0;
            best_found_nxt = 1'b0;
            state_nxt      = S_SCAN;
          end else if (in_cmd == CMD_INCREASE && in_table) begin
            state_nxt = S_INC;
          end
        end
      end
      S_INC: begin
        state_nxt = S_IDLE;
      end
      S_SCAN: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == LAST_IDX) begin
          cnt_nxt   = '0;
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt    = 1'b1;
          out_is_empty_nxt = !best_found_r;
          out_best_id_nxt  = best_found_r ? ID_W'(best_idx_r) : '0;
          state_nxt        = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      cnt_r        <= '0;
      cmd_count_r  <= '0;
      best_found_r <= 1'b0;
      rd_pend_r    <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cnt_r        <= cnt_nxt;
      cmd_count_r  <= cmd_count_nxt;
      best_found_r <= best_found_nxt;
      rd_pend_r    <= state_r == S_SCAN;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_idx_r       <= op_idx_nxt;
    op_delta_r     <= op_delta_nxt;
    best_level_r   <= best_level_nxt;
    best_stamp_r   <= best_stamp_nxt;
    best_idx_r     <= best_idx_nxt;
    rd_idx_r       <= cnt_r;
    out_is_empty_r <= out_is_empty_nxt;
    out_best_id_r  <= out_best_id_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_is_empty = out_is_empty_r;
  assign out_best_id  = out_best_id_r;

  // A new result appears only when a query scan has just finished.
  a_result_from_scan: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(state_r == S_DONE))
    else $error("result appeared without a finished scan");

  // The stamp counter advances by exactly one on each accepted transaction.
  a_stamp_step: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && $past(in_accept) |->
      cmd_count_r == STAMP_BITS'($past(cmd_count_r) + 1'b1))
    else $error("command counter did not advance on a transaction");

  // An empty result carries a zero id.
  a_empty_zero_id: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_empty |-> out_best_id == '0)
    else $error("empty result with nonzero id");

  // The memory is not written by an insert or remove while the clearing pass runs.
  a_clear_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_CLEAR |-> in_stall && mem_wdata == '0)
    else $error("transaction taken during clearing pass");

endmodule

### sv/impq_cmp.sv
// Shared ranking comparator for the priority queue scan.
// Depends on impq_pkg for the level width and the default stamp width.
module impq_cmp
  import impq_pkg::*;
#(
  parameter int unsigned STAMP_BITS = DEF_STAMP_BITS
) (
  input  logic                  cand_valid,
  input  logic [LEVEL_W-1:0]    cand_level,
  input  logic [STAMP_BITS-1:0] cand_stamp,
  input  logic                  best_found,
  input  logic [LEVEL_W-1:0]    best_level,
  input  logic [STAMP_BITS-1:0] best_stamp,
  output logic                  better
);

  logic level_gt;
  logic level_eq;
  logic stamp_lt;

  assign level_gt = cand_level > best_level;
  assign level_eq = cand_level == best_level;
  assign stamp_lt = cand_stamp < best_stamp;

  // A strict compare keeps the earlier scanned (lower) id on a full tie.
  assign better = cand_valid && (!best_found || level_gt || (level_eq && stamp_lt));

endmodule
